[src/trapezoid_profile_breakpoints_macros.svh]
// Assertion macros for the trapezoid profile breakpoint block.
// Used by the top level only; expects clk and rst in scope.
`ifndef TRAPEZOID_PROFILE_BREAKPOINTS_MACROS_SVH
`define TRAPEZOID_PROFILE_BREAKPOINTS_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TPB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked during reset.
`define TPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tpb_pkg.sv]
// Package for the trapezoid profile breakpoint block.
// Holds default widths and the profile kind codes; no dependencies.
`timescale 1ns / 1ps

package tpb_pkg;

  localparam int RATE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 24;
  localparam int ACCEL_BITS_DEF = 20;

  typedef enum logic [2:0] {
    KIND_TRAPEZOID  = 3'd0,
    KIND_PURE_DECEL = 3'd1,
    KIND_DECEL_TRI  = 3'd2,
    KIND_PURE_ACCEL = 3'd3,
    KIND_ACCEL_TRI  = 3'd4
  } kind_t;

endpackage

[src/tpb_if.sv]
// Valid/ready channel interfaces for motion blocks and breakpoints.
// Depends on tpb_pkg for the default widths and the kind type.
`timescale 1ns / 1ps

interface tpb_in_if import tpb_pkg::*; #(
  parameter int RATE_BITS  = RATE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int ACCEL_BITS = ACCEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [RATE_BITS-1:0]  entry_rate;
  logic [RATE_BITS-1:0]  exit_rate;
  logic [RATE_BITS-1:0]  cruise_rate;
  logic [ACCEL_BITS-1:0] accel_rate;
  logic [COUNT_BITS-1:0] step_count;

  modport source (output valid, entry_rate, exit_rate, cruise_rate, accel_rate,
                  step_count, input ready);
  modport sink   (input valid, entry_rate, exit_rate, cruise_rate, accel_rate,
                  step_count, output ready);
endinterface

interface tpb_out_if import tpb_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] accel_end;
  logic [COUNT_BITS-1:0] decel_start;
  kind_t                 profile_kind;

  modport source (output valid, accel_end, decel_start, profile_kind, input ready);
  modport sink   (input valid, accel_end, decel_start, profile_kind, output ready);
endinterface

[src/tpb_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per register stage,
// several numerators sharing one divisor, with a sideband carried along.
`timescale 1ns / 1ps

module tpb_div_pipe #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 21,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]              den,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  output logic [LANES-1:0][NUM_W-1:0]   quo,
  output logic [SIDE_W-1:0]             side_out
);

  logic                        vld  [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] nsh  [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem  [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] qacc [NUM_W];
  logic [DEN_W-1:0]            dreg [NUM_W];
  logic [SIDE_W-1:0]           sreg [NUM_W];

  for (genvar st = 0; st < NUM_W; st++) begin : g_stage
    logic                        c_vld;
    logic [LANES-1:0][NUM_W-1:0] c_num;
    logic [LANES-1:0][DEN_W-1:0] c_rem;
    logic [LANES-1:0][NUM_W-1:0] c_q;
    logic [DEN_W-1:0]            c_den;
    logic [SIDE_W-1:0]           c_side;
    logic [LANES-1:0][DEN_W-1:0] rem_next;
    logic [LANES-1:0]            qbit;

    if (st == 0) begin : g_first
      assign c_vld  = in_valid;
      assign c_num  = num;
      assign c_rem  = '0;
      assign c_q    = '0;
      assign c_den  = den;
      assign c_side = side_in;
    end else begin : g_rest
      assign c_vld  = vld[st-1];
      assign c_num  = nsh[st-1];
      assign c_rem  = rem[st-1];
      assign c_q    = qacc[st-1];
      assign c_den  = dreg[st-1];
      assign c_side = sreg[st-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] shifted;
      assign shifted     = {c_rem[l], c_num[l][NUM_W-1]};
      assign qbit[l]     = shifted >= {1'b0, c_den};
      assign rem_next[l] = qbit[l] ? DEN_W'(shifted - {1'b0, c_den}) : shifted[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[st] <= 1'b0;
      end else if (en) begin
        vld[st] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          nsh[st][l]  <= {c_num[l][NUM_W-2:0], 1'b0};
          qacc[st][l] <= {c_q[l][NUM_W-2:0], qbit[l]};
        end
        rem[st]  <= rem_next;
        dreg[st] <= c_den;
        sreg[st] <= c_side;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo       = qacc[NUM_W-1];
  assign side_out  = sreg[NUM_W-1];

endmodule

[src/trapezoid_profile_breakpoints.sv]
// Trapezoid profile breakpoints; RT_W is half the width of the peak-rate radicand.
// Throughput one transaction per cycle: every divider bit, root bit and arithmetic
// step has its own register stage, and the whole pipe holds when the output stalls.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "trapezoid_profile_breakpoints_macros.svh"

module trapezoid_profile_breakpoints import tpb_pkg::*; #(
  parameter int RATE_BITS  = RATE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int ACCEL_BITS = ACCEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tpb_in_if.sink    motion,
  tpb_out_if.source points
);

  // Derived widths: squared rates, doubled acceleration, radicand 4X and its root.
  localparam int SQ_W   = 2 * RATE_BITS;
  localparam int DEN_W  = ACCEL_BITS + 1;
  localparam int NA_W   = COUNT_BITS + ACCEL_BITS;
  localparam int FX_W   = ((SQ_W + 2 > NA_W + 2) ? SQ_W + 2 : NA_W + 2) + 1;
  localparam int RT_W   = (FX_W + 1) / 2;
  localparam int XP_W   = 2 * RT_W;
  localparam int RR_W   = RT_W + 3;
  localparam int SUM_W  = SQ_W + 1;

  // One shared advance: the pipe moves whenever the output register is empty or being taken.
  logic adv;
  logic o_vld;
  assign adv          = !o_vld || points.ready;
  assign motion.ready = adv;

  // ---------------------------------------------------------------------------
  // Stage A: capture the transaction, treat zero acceleration as one.
  // ---------------------------------------------------------------------------
  logic                  a_vld;
  logic [RATE_BITS-1:0]  a_vi, a_vf, a_vc;
  logic [ACCEL_BITS-1:0] a_a;
  logic [COUNT_BITS-1:0] a_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= motion.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_vi <= motion.entry_rate;
      a_vf <= motion.exit_rate;
      a_vc <= motion.cruise_rate;
      a_a  <= (motion.accel_rate == '0) ? ACCEL_BITS'(1) : motion.accel_rate;
      a_n  <= motion.step_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: squares of the three rates and n*a, each in its own multiplier.
  // ---------------------------------------------------------------------------
  logic                  b_vld;
  logic [SQ_W-1:0]       b_vi2, b_vf2, b_vc2;
  logic [NA_W-1:0]       b_na;
  logic                  b_up_on, b_dn_on, b_gt;
  logic [COUNT_BITS-1:0] b_n;
  logic [DEN_W-1:0]      b_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_vi2   <= SQ_W'(a_vi) * SQ_W'(a_vi);
      b_vf2   <= SQ_W'(a_vf) * SQ_W'(a_vf);
      b_vc2   <= SQ_W'(a_vc) * SQ_W'(a_vc);
      b_na    <= NA_W'(a_n) * NA_W'(a_a);
      b_up_on <= a_vi < a_vc;
      b_dn_on <= a_vf < a_vc;
      b_gt    <= a_vi > a_vf;
      b_n     <= a_n;
      b_den   <= {a_a, 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: numerators of the three distances and the radicand 4X.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                  up_on;
    logic                  dn_on;
    logic                  gt;
    logic [COUNT_BITS-1:0] n;
    logic [SQ_W-1:0]       vi2;
    logic [FX_W-1:0]       fx;
    logic [DEN_W-1:0]      den;
  } d1_side_t;

  logic                      c_vld;
  logic [2:0][SQ_W-1:0]      c_num;
  d1_side_t                  c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Rates below cruise give a strictly larger cruise square.
      c_num[0]     <= b_up_on ? b_vc2 - b_vi2 : '0;
      c_num[1]     <= b_dn_on ? b_vc2 - b_vf2 : '0;
      c_num[2]     <= b_gt ? b_vi2 - b_vf2 : b_vf2 - b_vi2;
      c_side.up_on <= b_up_on;
      c_side.dn_on <= b_dn_on;
      c_side.gt    <= b_gt;
      c_side.n     <= b_n;
      c_side.vi2   <= b_vi2;
      c_side.fx    <= ((FX_W'(b_vi2) + FX_W'(b_vf2)) << 1) + (FX_W'(b_na) << 2);
      c_side.den   <= b_den;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider bank: accel, decel and entry-to-exit distances in parallel.
  // ---------------------------------------------------------------------------
  logic                 d1_vld;
  logic [2:0][SQ_W-1:0] d1_q;
  d1_side_t             d1_side;

  tpb_div_pipe #(
    .LANES  (3),
    .NUM_W  (SQ_W),
    .DEN_W  (DEN_W),
    .SIDE_W ($bits(d1_side_t))
  ) u_div_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_vld),
    .num       (c_num),
    .den       (c_side.den),
    .side_in   (c_side),
    .out_valid (d1_vld),
    .quo       (d1_q),
    .side_out  (d1_side)
  );

  // ---------------------------------------------------------------------------
  // Stage D: classify the profile; triangles still need the peak rate.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    kind_t                 kind;
    logic [COUNT_BITS-1:0] acc;
    logic [COUNT_BITS-1:0] dec;
    logic [COUNT_BITS-1:0] n;
    logic [SQ_W-1:0]       vi2;
    logic [DEN_W-1:0]      den;
  } sq_side_t;

  logic            up_d, dn_d, tri_d;
  logic [SQ_W-1:0] up, dn, tri_dist;
  logic [SUM_W-1:0] up_dn;
  sq_side_t        dec_next;

  always_comb begin
    up_d     = d1_q[0] == '0;
    dn_d     = d1_q[1] == '0;
    tri_d    = d1_q[2] == '0;
    // Raise a zero distance to one step.
    up       = d1_side.up_on ? (up_d ? SQ_W'(1) : d1_q[0]) : '0;
    dn       = d1_side.dn_on ? (dn_d ? SQ_W'(1) : d1_q[1]) : '0;
    tri_dist = tri_d ? SQ_W'(1) : d1_q[2];
    up_dn    = SUM_W'(up) + SUM_W'(dn);

    dec_next.n   = d1_side.n;
    dec_next.vi2 = d1_side.vi2;
    dec_next.den = d1_side.den;
    if (up_dn < SUM_W'(d1_side.n)) begin
      dec_next.kind = KIND_TRAPEZOID;
      dec_next.acc  = COUNT_BITS'(up);
      dec_next.dec  = d1_side.n - COUNT_BITS'(dn);
    end else if (d1_side.gt) begin
      dec_next.acc  = '0;
      dec_next.dec  = '0;
      if (tri_dist >= SQ_W'(d1_side.n)) begin
        dec_next.kind = KIND_PURE_DECEL;
      end else begin
        dec_next.kind = KIND_DECEL_TRI;
      end
    end else begin
      dec_next.acc  = d1_side.n;
      dec_next.dec  = d1_side.n;
      if (tri_dist >= SQ_W'(d1_side.n)) begin
        dec_next.kind = KIND_PURE_ACCEL;
      end else begin
        dec_next.kind = KIND_ACCEL_TRI;
      end
    end
  end

  logic            e_vld;
  sq_side_t        e_side;
  logic [FX_W-1:0] e_fx;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_side <= dec_next;
      e_fx   <= d1_side.fx;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root of 4X: one root bit per stage, two radicand bits consumed each.
  // ---------------------------------------------------------------------------
  logic             rt_vld  [RT_W];
  logic [XP_W-1:0]  rt_x    [RT_W];
  logic [RR_W-1:0]  rt_rem  [RT_W];
  logic [RT_W-1:0]  rt_root [RT_W];
  sq_side_t         rt_side [RT_W];

  for (genvar st = 0; st < RT_W; st++) begin : g_root
    logic            c_v;
    logic [XP_W-1:0] c_x;
    logic [RR_W-1:0] c_rem;
    logic [RT_W-1:0] c_root;
    sq_side_t        c_sd;
    logic [RR_W-1:0] sh, trial;
    logic            ge;

    if (st == 0) begin : g_first
      assign c_v    = e_vld;
      assign c_x    = XP_W'(e_fx);
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_sd   = e_side;
    end else begin : g_rest
      assign c_v    = rt_vld[st-1];
      assign c_x    = rt_x[st-1];
      assign c_rem  = rt_rem[st-1];
      assign c_root = rt_root[st-1];
      assign c_sd   = rt_side[st-1];
    end

    assign sh    = {c_rem[RR_W-3:0], c_x[XP_W-1:XP_W-2]};
    assign trial = RR_W'({c_root, 2'b01});
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_vld[st] <= 1'b0;
      end else if (adv) begin
        rt_vld[st] <= c_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_x[st]    <= {c_x[XP_W-3:0], 2'b00};
        rt_rem[st]  <= ge ? sh - trial : sh;
        rt_root[st] <= {c_root[RT_W-2:0], ge};
        rt_side[st] <= c_sd;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages E, F, G: round the root to the peak rate, square it, subtract vi^2.
  // ---------------------------------------------------------------------------
  logic            f_vld, g_vld, h_vld;
  logic [RT_W-1:0] f_peak;
  logic [XP_W-1:0] g_psq, h_num;
  sq_side_t        f_side, g_side, h_side;
  logic [RT_W:0]   root_inc;

  assign root_inc = {1'b0, rt_root[RT_W-1]} + (RT_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= rt_vld[RT_W-1];
      g_vld <= f_vld;
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_peak <= root_inc[RT_W:1];
      f_side <= rt_side[RT_W-1];
      g_psq  <= XP_W'(f_peak) * XP_W'(f_peak);
      g_side <= f_side;
      h_num  <= (g_psq > XP_W'(g_side.vi2)) ? g_psq - XP_W'(g_side.vi2) : '0;
      h_side <= g_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Second divider: distance from the entry rate to the peak rate.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    kind_t                 kind;
    logic [COUNT_BITS-1:0] acc;
    logic [COUNT_BITS-1:0] dec;
    logic [COUNT_BITS-1:0] n;
  } d2_side_t;

  d2_side_t             h_d2;
  logic                 d2_vld;
  logic [0:0][XP_W-1:0] d2_q;
  d2_side_t             d2_side;

  assign h_d2 = '{kind: h_side.kind, acc: h_side.acc, dec: h_side.dec, n: h_side.n};

  tpb_div_pipe #(
    .LANES  (1),
    .NUM_W  (XP_W),
    .DEN_W  (DEN_W),
    .SIDE_W ($bits(d2_side_t))
  ) u_div_peak (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (h_vld),
    .num       (h_num),
    .den       (h_side.den),
    .side_in   (h_d2),
    .out_valid (d2_vld),
    .quo       (d2_q),
    .side_out  (d2_side)
  );

  // ---------------------------------------------------------------------------
  // Output register: triangles take the peak distance, saturated to n.
  // ---------------------------------------------------------------------------
  logic [XP_W-1:0]       peak_dist;
  logic [COUNT_BITS-1:0] peak_sat;
  logic                  is_tri;
  logic [COUNT_BITS-1:0] o_acc, o_dec;
  kind_t                 o_kind;

  assign peak_dist = (d2_q[0] == '0) ? XP_W'(1) : d2_q[0];
  assign peak_sat  = (peak_dist > XP_W'(d2_side.n)) ? d2_side.n : COUNT_BITS'(peak_dist);
  assign is_tri    = (d2_side.kind == KIND_DECEL_TRI) || (d2_side.kind == KIND_ACCEL_TRI);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_kind <= d2_side.kind;
      o_acc  <= is_tri ? peak_sat : d2_side.acc;
      o_dec  <= is_tri ? peak_sat : d2_side.dec;
    end
  end

  assign points.valid        = o_vld;
  assign points.accel_end    = o_acc;
  assign points.decel_start  = o_dec;
  assign points.profile_kind = o_kind;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `TPB_ASSERT_IMPL(a_order, o_vld, o_acc <= o_dec, "accel end beyond decel start")
  `TPB_ASSERT_IMPL(a_decel_zero, o_vld && (o_kind == KIND_PURE_DECEL), (o_acc == '0) && (o_dec == '0), "pure decel not at zero")
  `TPB_ASSERT_NEXT(a_reset_empty, rst, !o_vld && !a_vld, "pipe not empty after reset")

endmodule
